FILE: src/lbm_pkg.sv
`default_nettype none
package lbm_pkg;

  // field widths and modulus
  localparam int unsigned PRIME = 10007;
  localparam int CNT_W = 28;
  localparam int RES_W = 14;
  localparam int PW = $clog2(PRIME);
  // dividend width of the reduction unit: counts and digit products both fit
  localparam int XW = (CNT_W > 2 * PW) ? CNT_W : 2 * PW;
  // quotient width of an XW-bit dividend by PRIME
  localparam int QW = XW - PW + 1;
  localparam int PROD_W = XW + QW;

  // reciprocal for the reduction by PRIME
  localparam longint unsigned RECIP_L = (64'd1 << XW) / PRIME;
  localparam logic [QW-1:0] RECIP = QW'(RECIP_L);
  localparam logic [PW-1:0] P_VAL = PW'(PRIME);
  localparam logic [PW-1:0] P_MAX = PW'(PRIME - 1);

  // request to the shared modular unit
  typedef struct packed {
    logic          go;
    logic          is_mul;
    logic [XW-1:0] a;
    logic [PW-1:0] b;
  } mu_req_t;

  // answer of the shared modular unit
  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
    logic [PW-1:0] rem;
  } mu_rsp_t;

  // write port of the factorial tables
  typedef struct packed {
    logic          we_fact;
    logic          we_inv;
    logic [PW-1:0] addr;
    logic [PW-1:0] data;
  } tbl_wr_t;

endpackage
`default_nettype wire

FILE: src/lbm_modunit.sv
`default_nettype none
module lbm_modunit (
  input  logic            clk,
  input  logic            rst,
  input  lbm_pkg::mu_req_t req,
  output lbm_pkg::mu_rsp_t rsp
);
  import lbm_pkg::*;

  logic              v1;
  logic              v2;
  logic              v3;
  logic [XW-1:0]     x1;
  logic [XW-1:0]     x2;
  logic [QW-1:0]     est2;
  logic [QW-1:0]     est3;
  logic [PW:0]       r3;
  logic [PROD_W-1:0] scaled;
  logic [XW-1:0]     qp;
  logic [XW-1:0]     diff;
  logic              rsp_done;
  logic [QW-1:0]     rsp_quot;
  logic [PW-1:0]     rsp_rem;

  // quotient estimate by reciprocal, low by at most one
  assign scaled = PROD_W'(x1) * PROD_W'(RECIP);
  assign qp     = XW'(est2) * XW'(PRIME);
  assign diff   = x2 - qp;

  assign rsp = '{done: rsp_done, quot: rsp_quot, rem: rsp_rem};

  // valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      rsp_done <= 1'b0;
    end else begin
      v1       <= req.go;
      v2       <= v1;
      v3       <= v2;
      rsp_done <= v3;
    end
  end

  // datapath: product or pass, estimate, remainder, correction
  always_ff @(posedge clk) begin
    if (req.is_mul) begin
      x1 <= XW'(req.a[PW-1:0]) * XW'(req.b);
    end else begin
      x1 <= req.a;
    end
    est2 <= scaled[XW +: QW];
    x2   <= x1;
    est3 <= est2;
    r3   <= diff[PW:0];
    if (r3 >= {1'b0, P_VAL}) begin
      rsp_rem  <= PW'(r3 - {1'b0, P_VAL});
      rsp_quot <= est3 + QW'(1);
    end else begin
      rsp_rem  <= r3[PW-1:0];
      rsp_quot <= est3;
    end
  end

endmodule
`default_nettype wire

FILE: src/lbm_tables.sv
`default_nettype none
module lbm_tables (
  input  logic               clk,
  input  lbm_pkg::tbl_wr_t   wr,
  input  logic [lbm_pkg::PW-1:0] fact_addr,
  input  logic [lbm_pkg::PW-1:0] inv_addr,
  output logic [lbm_pkg::PW-1:0] fact_rd,
  output logic [lbm_pkg::PW-1:0] inv_rd
);
  import lbm_pkg::*;

  logic [PW-1:0] fact_mem [PRIME];
  logic [PW-1:0] inv_mem  [PRIME];

  // factorials mod prime
  always_ff @(posedge clk) begin
    if (wr.we_fact) begin
      fact_mem[wr.addr] <= wr.data;
    end
    fact_rd <= fact_mem[fact_addr];
  end

  // inverse factorials mod prime
  always_ff @(posedge clk) begin
    if (wr.we_inv) begin
      inv_mem[wr.addr] <= wr.data;
    end
    inv_rd <= inv_mem[inv_addr];
  end

endmodule
`default_nettype wire

FILE: src/lucas_binomial_mod_prime_top.sv
`default_nettype none
// each base-10007 digit of x+y (at most three) takes one pass of the digit loop; a negative
// count answers zero without entering the loop
// requests: one at a time, every step goes through one shared modular unit
// reset: synchronous; the factorial and inverse tables are then filled with busy high;
// done is a single-cycle strobe, the receiver cannot stall
module lucas_binomial_mod_prime_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [lbm_pkg::CNT_W-1:0] first_count,
  input  logic signed [lbm_pkg::CNT_W-1:0] second_count,
  output logic                          done,
  output logic [lbm_pkg::RES_W-1:0]     binomial_residue
);
  import lbm_pkg::*;

  typedef enum logic [3:0] {
    S_FILL_F,
    S_WAIT_F,
    S_FILL_I,
    S_WAIT_I,
    S_IDLE,
    S_DIGIT,
    S_WAIT_N,
    S_WAIT_K,
    S_RD1,
    S_RD2,
    S_WAIT_M1,
    S_WAIT_M2,
    S_WAIT_M3
  } state_t;

  state_t           state;
  logic [PW-1:0]    idx;
  logic [PW-1:0]    acc;
  logic [CNT_W-1:0] n_cnt;
  logic [CNT_W-1:0] k_cnt;
  logic [PW-1:0]    ni;
  logic [PW-1:0]    ki;
  logic [PW-1:0]    prod;
  logic [PW-1:0]    tmp;
  logic [PW-1:0]    fact_addr;
  logic [PW-1:0]    inv_addr;
  logic [PW-1:0]    fact_rd;
  logic [PW-1:0]    inv_rd;
  mu_req_t          mu_req;
  mu_rsp_t          mu_rsp;
  tbl_wr_t          wr;

  lbm_modunit u_modunit (
    .clk (clk),
    .rst (rst),
    .req (mu_req),
    .rsp (mu_rsp)
  );

  lbm_tables u_tables (
    .clk       (clk),
    .wr        (wr),
    .fact_addr (fact_addr),
    .inv_addr  (inv_addr),
    .fact_rd   (fact_rd),
    .inv_rd    (inv_rd)
  );

  assign busy = (state != S_IDLE);

  // sequencer: table fill after reset, then digit loop per request
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL_F;
      idx        <= '0;
      acc        <= PW'(1);
      mu_req.go  <= 1'b0;
      wr.we_fact <= 1'b0;
      wr.we_inv  <= 1'b0;
      done       <= 1'b0;
    end else begin
      mu_req.go  <= 1'b0;
      wr.we_fact <= 1'b0;
      wr.we_inv  <= 1'b0;
      done       <= 1'b0;
      case (state)
        // fact[i] = fact[i-1] * i
        S_FILL_F: begin
          wr.we_fact <= 1'b1;
          wr.addr    <= idx;
          wr.data    <= acc;
          if (idx == P_MAX) begin
            // (p-1)! is -1 mod p, its own inverse
            idx   <= P_MAX;
            acc   <= P_MAX;
            state <= S_FILL_I;
          end else begin
            mu_req <= '{go: 1'b1, is_mul: 1'b1, a: XW'(acc), b: idx + PW'(1)};
            state  <= S_WAIT_F;
          end
        end
        S_WAIT_F: begin
          if (mu_rsp.done) begin
            acc   <= mu_rsp.rem;
            idx   <= idx + PW'(1);
            state <= S_FILL_F;
          end
        end
        // inv[i-1] = inv[i] * i
        S_FILL_I: begin
          wr.we_inv <= 1'b1;
          wr.addr   <= idx;
          wr.data   <= acc;
          if (idx == '0) begin
            state <= S_IDLE;
          end else begin
            mu_req <= '{go: 1'b1, is_mul: 1'b1, a: XW'(acc), b: idx};
            state  <= S_WAIT_I;
          end
        end
        S_WAIT_I: begin
          if (mu_rsp.done) begin
            acc   <= mu_rsp.rem;
            idx   <= idx - PW'(1);
            state <= S_FILL_I;
          end
        end
        // take a request; negative count answers zero at once
        S_IDLE: begin
          if (start) begin
            if (first_count[CNT_W-1] || second_count[CNT_W-1]) begin
              done             <= 1'b1;
              binomial_residue <= '0;
            end else begin
              n_cnt <= $unsigned(first_count) + $unsigned(second_count);
              k_cnt <= $unsigned(first_count);
              prod  <= PW'(1);
              state <= S_DIGIT;
            end
          end
        end
        // next digit or finish
        S_DIGIT: begin
          if (n_cnt == '0) begin
            done             <= 1'b1;
            binomial_residue <= RES_W'(prod);
            state            <= S_IDLE;
          end else begin
            mu_req <= '{go: 1'b1, is_mul: 1'b0, a: XW'(n_cnt), b: '0};
            state  <= S_WAIT_N;
          end
        end
        S_WAIT_N: begin
          if (mu_rsp.done) begin
            ni     <= mu_rsp.rem;
            n_cnt  <= CNT_W'(mu_rsp.quot);
            mu_req <= '{go: 1'b1, is_mul: 1'b0, a: XW'(k_cnt), b: '0};
            state  <= S_WAIT_K;
          end
        end
        S_WAIT_K: begin
          if (mu_rsp.done) begin
            ki    <= mu_rsp.rem;
            k_cnt <= CNT_W'(mu_rsp.quot);
            if (mu_rsp.rem > ni) begin
              // lower digit above upper digit: binomial vanishes
              done             <= 1'b1;
              binomial_residue <= '0;
              state            <= S_IDLE;
            end else begin
              fact_addr <= ni;
              inv_addr  <= mu_rsp.rem;
              state     <= S_RD1;
            end
          end
        end
        S_RD1: begin
          inv_addr <= ni - ki;
          state    <= S_RD2;
        end
        // fact[ni], then inv[ki], then inv[ni-ki]
        S_RD2: begin
          tmp    <= inv_rd;
          mu_req <= '{go: 1'b1, is_mul: 1'b1, a: XW'(prod), b: fact_rd};
          state  <= S_WAIT_M1;
        end
        S_WAIT_M1: begin
          if (mu_rsp.done) begin
            mu_req <= '{go: 1'b1, is_mul: 1'b1, a: XW'(mu_rsp.rem), b: tmp};
            state  <= S_WAIT_M2;
          end
        end
        S_WAIT_M2: begin
          if (mu_rsp.done) begin
            mu_req <= '{go: 1'b1, is_mul: 1'b1, a: XW'(mu_rsp.rem), b: inv_rd};
            state  <= S_WAIT_M3;
          end
        end
        S_WAIT_M3: begin
          if (mu_rsp.done) begin
            prod  <= mu_rsp.rem;
            state <= S_DIGIT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result always reduced
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (binomial_residue < RES_W'(PRIME)))
    else $error("residue out of range");

  // a result only comes out when the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // negative count answers zero on the next cycle
  a_neg_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (first_count[CNT_W-1] || second_count[CNT_W-1]))
      |=> (done && (binomial_residue == '0)))
    else $error("negative count not answered with zero");

  // reduction unit remainder fully corrected
  a_unit_rem: assert property (@(posedge clk) disable iff (rst)
    mu_rsp.done |-> (mu_rsp.rem < P_VAL))
    else $error("unit remainder not reduced");

endmodule
`default_nettype wire

FILE: verif/lucas_binomial_mod_prime_top_tb.sv
`timescale 1ns / 1ps

module lucas_binomial_mod_prime_top_tb;
  import lbm_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int P_SQ = PRIME * PRIME;

  typedef logic signed [CNT_W-1:0] count_t;
  typedef logic [RES_W-1:0] residue_t;

  typedef struct {
    count_t x;
    count_t y;
  } count_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  count_t first_count = '0;
  count_t second_count = '0;
  logic done;
  residue_t binomial_residue;

  // factorials and inverse factorials mod the prime
  longint fact_tbl [0:PRIME-1];
  longint inv_fact_tbl [0:PRIME-1];

  count_pair_t pending_pairs[$];
  residue_t expected_residues[$];
  logic req_taken = 1'b0;
  int idle_left = 0;
  int burst_left = 0;
  int total_items = 0;
  int accepted_count = 0;
  int error_count = 0;
  int cycle_count = 0;

  lucas_binomial_mod_prime_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .first_count      (first_count),
    .second_count     (second_count),
    .done             (done),
    .binomial_residue (binomial_residue)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // C(x+y, x) mod prime, digit by digit in base prime
  function automatic residue_t lucas_residue(count_t x, count_t y);
    longint unsigned n;
    longint unsigned k;
    longint unsigned nd;
    longint unsigned kd;
    longint unsigned prod;
    if (x < 0 || y < 0) begin
      return '0;
    end
    k = longint'(x);
    n = k + longint'(y);
    prod = 1;
    while (n > 0 && prod != 0) begin
      nd = n % PRIME;
      kd = k % PRIME;
      if (kd > nd) begin
        prod = 0;
      end else begin
        prod = (prod * fact_tbl[nd]) % PRIME;
        prod = (prod * inv_fact_tbl[kd]) % PRIME;
        prod = (prod * inv_fact_tbl[nd - kd]) % PRIME;
      end
      n = n / PRIME;
      k = k / PRIME;
    end
    return residue_t'(prod);
  endfunction

  // random count: small, near multiples of the prime, wide, or negative
  function automatic count_t rand_count();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      return {1'b1, (CNT_W-1)'($urandom)};
    end else if (sel < 35) begin
      return count_t'($urandom_range(0, 300));
    end else if (sel < 60) begin
      v = ($urandom_range(0, 1) ? P_SQ : 0) + $urandom_range(0, 12) * PRIME;
      v = v + $urandom_range(0, 10) - 5;
      if (v < 0) begin
        v = 0;
      end
      return count_t'(v);
    end else if (sel < 70) begin
      return count_t'($urandom_range(0, PRIME - 1));
    end else if (sel < 85) begin
      return {1'b0, (CNT_W-1)'($urandom)};
    end else begin
      return count_t'($urandom);
    end
  endfunction

  // idle length after a request: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 4);
    end else if (r < 97) begin
      return $urandom_range(5, 30);
    end else begin
      return $urandom_range(40, 200);
    end
  endfunction

  task automatic add_pair(input count_t x, input count_t y);
    count_pair_t pair;
    pair.x = x;
    pair.y = y;
    pending_pairs = {pending_pairs, pair};
  endtask

  // request driver, holds a request until the block takes it
  always @(negedge clk) begin : drive
    count_pair_t pair;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      start <= 1'b1;
    end else if (idle_left > 0) begin
      start <= 1'b0;
      idle_left <= idle_left - 1;
    end else if (pending_pairs.size() > 0) begin
      pair = pending_pairs.pop_front();
      first_count <= pair.x;
      second_count <= pair.y;
      start <= 1'b1;
      if (burst_left > 0) begin
        burst_left <= burst_left - 1;
        idle_left <= 0;
      end else if ($urandom_range(0, 19) == 0) begin
        burst_left <= $urandom_range(10, 30);
        idle_left <= 0;
      end else begin
        idle_left <= pick_gap();
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: record accepted requests, check results in order
  always @(posedge clk) begin : watch
    residue_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
      if (start && !busy) begin
        expected_residues = {expected_residues, lucas_residue(first_count, second_count)};
        accepted_count++;
      end
      if (done) begin
        if (expected_residues.size() == 0) begin
          $error("binomial_residue: expected none, actual %0d", binomial_residue);
          error_count++;
        end else begin
          want = expected_residues.pop_front();
          if (binomial_residue !== want) begin
            $error("binomial_residue: expected %0d, actual %0d", want, binomial_residue);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : main
    longint r0;
    longint r1;
    longint t0;
    longint t1;
    longint q;
    longint rn;
    longint tn;

    // factorial table, then the inverse of the top entry by extended euclid
    fact_tbl[0] = 1;
    for (int i = 1; i < PRIME; i++) begin
      fact_tbl[i] = (fact_tbl[i-1] * i) % PRIME;
    end
    r0 = PRIME;
    r1 = fact_tbl[PRIME-1];
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      rn = r0 - q * r1;
      tn = t0 - q * t1;
      r0 = r1;
      r1 = rn;
      t0 = t1;
      t1 = tn;
    end
    // signed remainder, so keep the modulus signed
    t0 = t0 % longint'(PRIME);
    if (t0 < 0) begin
      t0 = t0 + longint'(PRIME);
    end
    inv_fact_tbl[PRIME-1] = t0;
    for (int i = PRIME - 1; i > 0; i--) begin
      inv_fact_tbl[i-1] = (inv_fact_tbl[i] * i) % PRIME;
    end

    // directed requests
    add_pair(count_t'(0), count_t'(0));                      // empty product
    add_pair(count_t'(-1), count_t'(5));                     // negative lower count
    add_pair(count_t'(5), count_t'(-1));                     // negative upper count
    add_pair({1'b1, {(CNT_W-1){1'b0}}}, {1'b1, {(CNT_W-1){1'b0}}});
    add_pair({1'b0, {(CNT_W-1){1'b1}}}, {1'b0, {(CNT_W-1){1'b1}}});
    add_pair(count_t'(0), {1'b0, {(CNT_W-1){1'b1}}});
    add_pair({1'b0, {(CNT_W-1){1'b1}}}, count_t'(0));
    add_pair(count_t'(-1), count_t'(-1));
    add_pair(count_t'(3), count_t'(4));
    add_pair(count_t'(PRIME - 1), count_t'(0));
    add_pair(count_t'(PRIME - 1), count_t'(1));              // low digit of k above that of n
    add_pair(count_t'(PRIME), count_t'(PRIME));
    add_pair(count_t'(PRIME - 1), count_t'(PRIME - 1));
    add_pair(count_t'(5000), count_t'(5006));
    add_pair(count_t'(1), count_t'(P_SQ - 2));
    add_pair(count_t'(P_SQ), count_t'(P_SQ));
    add_pair(count_t'(P_SQ - 1), count_t'(1));               // all digits of n zero but the top
    add_pair(count_t'(123456), count_t'(7654321));
    add_pair(count_t'(0), count_t'(1));
    add_pair(count_t'(1), count_t'(0));

    // random requests
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_pair(rand_count(), rand_count());
    end
    total_items = pending_pairs.size();
    idle_left = pick_gap();

    // reset, then let the driver run
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (accepted_count < total_items) @(posedge clk);
    while (expected_residues.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
